// ----- hw/rtl/vrle_pkg.sv -----
`default_nettype none

package vrle_pkg;

	typedef enum logic [1:0] {
		FUNC_BLOCK = 2'd0,
		FUNC_LIGHT = 2'd1,
		FUNC_SUN   = 2'd2,
		FUNC_RAW   = 2'd3
	} func_t;

	localparam int unsigned TOTAL_W = 20;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 20'hFFFFF;
	localparam logic [TOTAL_W-1:0] LIMIT_RESET = 20'd524288;

	localparam logic [2:0] REC_BYTES_BLOCK = 3'd4;
	localparam logic [2:0] REC_BYTES_LIGHT = 3'd3;
	localparam logic [2:0] REC_BYTES_RAW   = 3'd1;

	// records produced by one item, in order: rec0 first
	typedef struct packed {
		logic push0;
		logic push1;
	} push_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vrle_encode.sv -----
`default_nettype none

module vrle_encode #(
	parameter int unsigned COUNT_WIDTH = 16,
	parameter int unsigned VALUE_WIDTH = 16,
	parameter int unsigned REC_W = COUNT_WIDTH + VALUE_WIDTH + 3 + vrle_pkg::TOTAL_W + 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    func,
	input  wire logic [15:0]                   value,
	input  wire logic                          section_end,
	input  wire logic [vrle_pkg::TOTAL_W-1:0]  byte_limit,
	input  wire logic                          room,
	output vrle_pkg::push_t                    push,
	output logic [REC_W-1:0]                   rec0,
	output logic [REC_W-1:0]                   rec1
);

	localparam int unsigned TW = vrle_pkg::TOTAL_W;

	function automatic logic [2:0] bytes_of(input vrle_pkg::func_t f);
		logic [2:0] nb;
		unique case (f)
			vrle_pkg::FUNC_BLOCK: nb = vrle_pkg::REC_BYTES_BLOCK;
			vrle_pkg::FUNC_LIGHT: nb = vrle_pkg::REC_BYTES_LIGHT;
			vrle_pkg::FUNC_SUN:   nb = vrle_pkg::REC_BYTES_LIGHT;
			vrle_pkg::FUNC_RAW:   nb = vrle_pkg::REC_BYTES_RAW;
		endcase
		return nb;
	endfunction

	function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [2:0] b);
		logic [TW:0] s;
		s = {1'b0, a} + {{(TW-2){1'b0}}, b};
		return s[TW] ? vrle_pkg::TOTAL_MAX : s[TW-1:0];
	endfunction

	// input register
	logic                  valid_s1;
	vrle_pkg::func_t       func_s1;
	logic [15:0]           value_s1;
	logic                  end_s1;

	// run state
	logic [VALUE_WIDTH-1:0] open_value_q;
	logic [COUNT_WIDTH-1:0] open_count_q;
	logic                   run_open_q;
	vrle_pkg::func_t        open_func_q;
	logic [TW-1:0]          bytes_q;
	logic                   ovf_q;

	logic                   advance;
	logic                   is_raw;
	logic [VALUE_WIDTH-1:0] v_masked;
	logic                   match;
	logic                   flush_old;
	logic                   has_second;
	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [COUNT_WIDTH-1:0] sec_count;
	logic [VALUE_WIDTH-1:0] sec_value;
	logic [2:0]             sec_nb;
	logic [COUNT_WIDTH-1:0] fst_count;
	logic [VALUE_WIDTH-1:0] fst_value;
	logic [2:0]             fst_nb;
	logic [TW-1:0]          t1;
	logic [TW-1:0]          t2;
	logic                   ov1;
	logic                   ov2;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1  <= vrle_pkg::func_t'(func);
			value_s1 <= value;
			end_s1   <= section_end;
		end
	end

	always_comb begin
		is_raw   = (func_s1 == vrle_pkg::FUNC_RAW);
		v_masked = (func_s1 == vrle_pkg::FUNC_BLOCK) ? value_s1[VALUE_WIDTH-1:0]
		                                             : VALUE_WIDTH'(value_s1[7:0]);
		match    = run_open_q && (open_func_q == func_s1) && (open_value_q == v_masked)
		           && (open_count_q != {COUNT_WIDTH{1'b1}});
		flush_old  = run_open_q && (is_raw || !match);
		has_second = is_raw || end_s1;
		cnt_inc    = open_count_q + COUNT_WIDTH'(1);

		if (is_raw) begin
			sec_count = '0;
			sec_value = VALUE_WIDTH'(value_s1[7:0]);
			sec_nb    = vrle_pkg::REC_BYTES_RAW;
		end else begin
			sec_count = match ? cnt_inc : COUNT_WIDTH'(1);
			sec_value = v_masked;
			sec_nb    = bytes_of(func_s1);
		end

		if (flush_old) begin
			fst_count = open_count_q;
			fst_value = open_value_q;
			fst_nb    = bytes_of(open_func_q);
		end else begin
			fst_count = sec_count;
			fst_value = sec_value;
			fst_nb    = sec_nb;
		end

		t1  = sat_add(bytes_q, fst_nb);
		ov1 = ovf_q || (t1 >= byte_limit);
		t2  = sat_add(t1, sec_nb);
		ov2 = ov1 || (t2 >= byte_limit);

		push.push0 = advance && (flush_old || has_second);
		push.push1 = advance && flush_old && has_second;

		rec0 = {fst_count, fst_value, fst_nb, t1, ov1, !(flush_old && has_second)};
		rec1 = {sec_count, sec_value, sec_nb, t2, ov2, 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_value_q <= '0;
			open_count_q <= '0;
			run_open_q   <= 1'b0;
			open_func_q  <= vrle_pkg::FUNC_BLOCK;
			bytes_q      <= '0;
			ovf_q        <= 1'b0;
		end else if (advance) begin
			if (push.push1) begin
				bytes_q <= t2;
				ovf_q   <= ov2;
			end else if (push.push0) begin
				bytes_q <= t1;
				ovf_q   <= ov1;
			end
			if (is_raw) begin
				run_open_q   <= 1'b0;
				open_count_q <= '0;
			end else if (end_s1) begin
				run_open_q   <= 1'b0;
				open_count_q <= '0;
			end else if (match) begin
				open_count_q <= cnt_inc;
			end else begin
				run_open_q   <= 1'b1;
				open_func_q  <= func_s1;
				open_value_q <= v_masked;
				open_count_q <= COUNT_WIDTH'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/vrle_fifo.sv -----
`default_nettype none

module vrle_fifo #(
	parameter int unsigned WIDTH = 72
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire vrle_pkg::push_t  push,
	input  wire logic [WIDTH-1:0] wr_data0,
	input  wire logic [WIDTH-1:0] wr_data1,
	output logic                  room,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic [WIDTH-1:0]      rd_data
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PW    = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;
	logic             pop;
	logic [PW:0]      n_push;

	assign room     = (count_q <= (PW+1)'(DEPTH - 2));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign pop      = rd_valid && rd_ready;
	assign n_push   = (PW+1)'(push.push0) + (PW+1)'(push.push1);

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= wr_data0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_q + PW'(1)] <= wr_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[PW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + n_push - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/voxel_run_length_encoder_core.sv -----
// Run-length encoder for voxel sections. Each accepted item is one voxel value tagged
// with its section (block id, light, sunlight or raw byte); the block emits count/value
// records, one per output transaction, with the running byte total and a sticky
// overflow flag against byte_limit. An item is held in the encode register and produces
// zero, one or two records, so one item enters per cycle while the queue has room and
// items give at most one record each; an item that closes one run and emits a second
// record needs a second transaction on the single-record output port behind a
// four-entry queue. byte_limit is written through the cfg channel, which is always
// ready, and should only change while idle.
`default_nettype none

module voxel_run_length_encoder_core #(
	parameter int unsigned COUNT_WIDTH = 16,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [vrle_pkg::TOTAL_W-1:0] cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   func,
	input  wire logic [15:0]                  value,
	input  wire logic                         section_end,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [COUNT_WIDTH-1:0]            run_count,
	output logic [VALUE_WIDTH-1:0]            run_value,
	output logic [2:0]                        record_bytes,
	output logic [vrle_pkg::TOTAL_W-1:0]      byte_total,
	output logic                              overflow,
	output logic                              last_of_item
);

	localparam int unsigned REC_W = COUNT_WIDTH + VALUE_WIDTH + 3 + vrle_pkg::TOTAL_W + 2;

	logic [vrle_pkg::TOTAL_W-1:0] byte_limit_q;
	vrle_pkg::push_t              push;
	logic [REC_W-1:0]             rec0;
	logic [REC_W-1:0]             rec1;
	logic [REC_W-1:0]             rd_data;
	logic                         room;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_limit_q <= vrle_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			byte_limit_q <= cfg_data;
		end
	end

	vrle_encode #(
		.COUNT_WIDTH (COUNT_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH),
		.REC_W       (REC_W)
	) u_encode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.value       (value),
		.section_end (section_end),
		.byte_limit  (byte_limit_q),
		.room        (room),
		.push        (push),
		.rec0        (rec0),
		.rec1        (rec1)
	);

	vrle_fifo #(
		.WIDTH (REC_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data0 (rec0),
		.wr_data1 (rec1),
		.room     (room),
		.rd_valid (out_valid),
		.rd_ready (out_ready),
		.rd_data  (rd_data)
	);

	assign {run_count, run_value, record_bytes, byte_total, overflow, last_of_item} = rd_data;

	// first record of a pair: the second is already queued
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_item |=> out_valid)
		else $error("second record of an item missing");

	a_rec_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (record_bytes == vrle_pkg::REC_BYTES_BLOCK)
		           || (record_bytes == vrle_pkg::REC_BYTES_LIGHT)
		           || (record_bytes == vrle_pkg::REC_BYTES_RAW))
		else $error("bad record size");

	a_raw_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((record_bytes == vrle_pkg::REC_BYTES_RAW) == (run_count == '0)))
		else $error("raw record and zero count disagree");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && overflow ##1 out_valid |-> overflow)
		else $error("overflow flag dropped");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import vrle_pkg::*;

	typedef struct packed {
		logic [15:0]        cnt;
		logic [15:0]        val;
		logic [2:0]         nbytes;
		logic [TOTAL_W-1:0] total;
		logic               ovf;
		logic               last;
	} voxel_rec_t;

	typedef struct packed {
		func_t       f;
		logic [15:0] v;
		logic        e;
		logic        typed;
		voxel_rec_t  rec;
	} voxel_row_t;

	localparam voxel_rec_t NO_REC = '0;

	// opening rows are typed in; they assume the reset value of byte_limit
	localparam voxel_row_t DIRECTED [0:22] = '{
		'{FUNC_RAW,   16'hFFFF, 1'b1, 1'b1, '{16'd0, 16'h00FF, REC_BYTES_RAW,   20'd1,  1'b0, 1'b1}},
		'{FUNC_BLOCK, 16'hFFFF, 1'b1, 1'b1, '{16'd1, 16'hFFFF, REC_BYTES_BLOCK, 20'd5,  1'b0, 1'b1}},
		'{FUNC_LIGHT, 16'hFFFF, 1'b1, 1'b1, '{16'd1, 16'h00FF, REC_BYTES_LIGHT, 20'd8,  1'b0, 1'b1}},
		'{FUNC_SUN,   16'h0000, 1'b1, 1'b1, '{16'd1, 16'h0000, REC_BYTES_LIGHT, 20'd11, 1'b0, 1'b1}},
		'{FUNC_BLOCK, 16'h0000, 1'b0, 1'b0, NO_REC},
		'{FUNC_BLOCK, 16'h0000, 1'b0, 1'b0, NO_REC},
		'{FUNC_BLOCK, 16'h0000, 1'b1, 1'b0, NO_REC},
		'{FUNC_BLOCK, 16'h0005, 1'b0, 1'b0, NO_REC},
		'{FUNC_BLOCK, 16'h0006, 1'b0, 1'b0, NO_REC},
		'{FUNC_LIGHT, 16'h0006, 1'b0, 1'b0, NO_REC},
		'{FUNC_LIGHT, 16'h1206, 1'b0, 1'b0, NO_REC},
		'{FUNC_SUN,   16'h0006, 1'b0, 1'b0, NO_REC},
		'{FUNC_RAW,   16'hAB55, 1'b0, 1'b0, NO_REC},
		'{FUNC_RAW,   16'h0000, 1'b1, 1'b0, NO_REC},
		'{FUNC_LIGHT, 16'h0007, 1'b0, 1'b0, NO_REC},
		'{FUNC_LIGHT, 16'h0007, 1'b1, 1'b0, NO_REC},
		'{FUNC_BLOCK, 16'h8000, 1'b1, 1'b0, NO_REC},
		'{FUNC_SUN,   16'h00FF, 1'b0, 1'b0, NO_REC},
		'{FUNC_SUN,   16'hFFFF, 1'b1, 1'b0, NO_REC},
		'{FUNC_BLOCK, 16'h00FF, 1'b0, 1'b0, NO_REC},
		'{FUNC_BLOCK, 16'hFF00, 1'b1, 1'b0, NO_REC},
		'{FUNC_RAW,   16'h5A5A, 1'b0, 1'b0, NO_REC},
		'{FUNC_LIGHT, 16'h0001, 1'b0, 1'b0, NO_REC}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [TOTAL_W-1:0] cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         func;
	logic [15:0]        value;
	logic               section_end;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [15:0]        run_count;
	logic [15:0]        run_value;
	logic [2:0]         record_bytes;
	logic [TOTAL_W-1:0] byte_total;
	logic               overflow;
	logic               last_of_item;

	logic               row_typed;
	voxel_rec_t         row_rec;

	voxel_rec_t         pending_records [$];
	int                 errors = 0;

	// encoder state as the testbench sees it
	logic [TOTAL_W-1:0] limit_now    = LIMIT_RESET;
	logic [15:0]        run_val_now  = '0;
	logic [15:0]        run_len_now  = '0;
	logic               run_is_open  = 1'b0;
	func_t              run_func_now = FUNC_BLOCK;
	logic [TOTAL_W-1:0] bytes_now    = '0;
	logic               ovf_now      = 1'b0;

	voxel_rec_t         step_recs [2];
	int                 step_n;

	int                 burst_left = 0;
	int                 stall_left = 0;
	logic [31:0]        stall_pat;

	voxel_run_length_encoder_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.value        (value),
		.section_end  (section_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.run_count    (run_count),
		.run_value    (run_value),
		.record_bytes (record_bytes),
		.byte_total   (byte_total),
		.overflow     (overflow),
		.last_of_item (last_of_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("voxel_run_length_encoder_core regression: fail");
		$finish;
	end

	function automatic logic [2:0] record_size(input func_t f);
		case (f)
			FUNC_BLOCK: return REC_BYTES_BLOCK;
			FUNC_RAW:   return REC_BYTES_RAW;
			default:    return REC_BYTES_LIGHT;
		endcase
	endfunction

	task automatic close_record(input logic [15:0] cnt, input logic [15:0] val,
			input logic [2:0] nb);
		logic [TOTAL_W:0] sum;
		sum = {1'b0, bytes_now} + nb;
		bytes_now = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
		if (bytes_now >= limit_now)
			ovf_now = 1'b1;
		step_recs[step_n] = '{cnt, val, nb, bytes_now, ovf_now, 1'b0};
		step_n++;
	endtask

	task automatic flush_run();
		if (run_is_open) begin
			close_record(run_len_now, run_val_now, record_size(run_func_now));
			run_is_open = 1'b0;
			run_len_now = '0;
		end
	endtask

	task automatic encode_voxel(input func_t f, input logic [15:0] v, input logic e,
			input logic typed, input voxel_rec_t typed_rec);
		logic [15:0] kept;
		step_n = 0;
		if (f == FUNC_RAW) begin
			flush_run();
			close_record(16'd0, {8'd0, v[7:0]}, REC_BYTES_RAW);
		end else begin
			kept = (f == FUNC_BLOCK) ? v : {8'd0, v[7:0]};
			if (run_is_open && run_func_now == f && run_val_now == kept
					&& run_len_now != 16'hFFFF) begin
				run_len_now++;
			end else begin
				flush_run();
				run_is_open  = 1'b1;
				run_func_now = f;
				run_val_now  = kept;
				run_len_now  = 16'd1;
			end
			if (e)
				flush_run();
		end
		if (step_n > 0)
			step_recs[step_n-1].last = 1'b1;
		if (typed && step_n == 1)
			step_recs[0] = typed_rec;
		for (int i = 0; i < step_n; i++)
			pending_records.insert(pending_records.size(), step_recs[i]);
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d (0x%0h), got %0d (0x%0h)", name, want, want, got, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		voxel_rec_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_records.size() == 0) begin
					$error("record with none pending: count %0d value 0x%0h",
						run_count, run_value);
					errors++;
				end else begin
					want = pending_records.pop_front();
					compare_field("run_count", want.cnt, run_count);
					compare_field("run_value", want.val, run_value);
					compare_field("record_bytes", want.nbytes, record_bytes);
					compare_field("byte_total", want.total, byte_total);
					compare_field("overflow", want.ovf, overflow);
					compare_field("last_of_item", want.last, last_of_item);
				end
			end
			if (cfg_valid && cfg_ready)
				limit_now = cfg_data;
			if (in_valid && in_ready)
				encode_voxel(func_t'(func), value, section_end, row_typed, row_rec);
		end
	end

	// receiver stalls in windows, each with its own pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left = 32;
			case ($urandom_range(0, 3))
				0: stall_pat = '1;
				1: stall_pat = $urandom;
				2: stall_pat = $urandom | $urandom;
				default: stall_pat = 32'hEEEE_EEEE;
			endcase
		end
		out_ready <= stall_pat[0];
		stall_pat = {stall_pat[0], stall_pat[31:1]};
		stall_left--;
	end

	task automatic push_voxel(input func_t f, input logic [15:0] v, input logic e,
			input logic typed = 1'b0, input voxel_rec_t typed_rec = '0);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
		end
		burst_left--;
		in_valid    <= 1'b1;
		func        <= f;
		value       <= v;
		section_end <= e;
		row_typed   <= typed;
		row_rec     <= typed_rec;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic wait_for_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		for (int k = 0; k < 4000 && pending_records.size() != 0; k++)
			@(posedge clk);
		if (pending_records.size() != 0) begin
			$error("%0d records never arrived", pending_records.size());
			errors++;
			pending_records.delete();
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(input logic [TOTAL_W-1:0] lim);
		cfg_valid <= 1'b1;
		cfg_data  <= lim;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed sections with random runs, some raw bytes, some noise
	task automatic random_voxels(input int count);
		int          sent;
		int          len;
		func_t       f;
		logic [15:0] v;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 9))
				7, 8: begin
					len = $urandom_range(1, 4);
					for (int j = 0; j < len; j++)
						push_voxel(FUNC_RAW, 16'($urandom), 1'($urandom));
					sent += len;
				end
				9: begin
					len = $urandom_range(1, 8);
					for (int j = 0; j < len; j++)
						push_voxel(func_t'($urandom_range(0, 3)), 16'($urandom),
							1'($urandom));
					sent += len;
				end
				default: begin
					f   = func_t'($urandom_range(0, 2));
					len = $urandom_range(1, 16);
					v   = 16'($urandom);
					for (int j = 0; j < len; j++) begin
						if ($urandom_range(0, 3) == 0)
							v = ($urandom_range(0, 1) != 0) ? 16'($urandom) : v ^ 16'd1;
						if (f != FUNC_BLOCK)
							v[15:8] = 8'($urandom);
						push_voxel(f, v, j == len - 1);
					end
					sent += len;
				end
			endcase
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		func        <= FUNC_BLOCK;
		value       <= '0;
		section_end <= 1'b0;
		row_typed   <= 1'b0;
		row_rec     <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			push_voxel(DIRECTED[i].f, DIRECTED[i].v, DIRECTED[i].e, DIRECTED[i].typed,
				DIRECTED[i].rec);
		wait_for_idle();

		write_limit(bytes_now + TOTAL_W'($urandom_range(50, 600)));
		random_voxels(500);
		wait_for_idle();

		write_limit('0);
		random_voxels(300);
		wait_for_idle();

		write_limit(TOTAL_W'($urandom));
		random_voxels(600);
		wait_for_idle();

		write_limit(TOTAL_MAX);
		random_voxels(30);
		wait_for_idle();

		if (errors == 0)
			$display("voxel_run_length_encoder_core regression: pass");
		else
			$display("voxel_run_length_encoder_core regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/vrle_pkg.sv
hw/rtl/vrle_encode.sv
hw/rtl/vrle_fifo.sv
hw/rtl/voxel_run_length_encoder_core.sv
tb/testbench.sv
